### hdl/ps2m_pkg.sv
package ps2m_pkg;

    // Event codes carried on the result channel
    typedef enum logic [1:0] {
        EVT_MOVE  = 2'd0,
        EVT_WHEEL = 2'd1,
        EVT_DOWN  = 2'd2,
        EVT_UP    = 2'd3
    } t_evt_kind;

    // Header byte layout
    localparam logic [7:0] HDR_SYNC_MASK = 8'h08;
    localparam logic [7:0] HDR_OVF_MASK  = 8'hC0;
    localparam int unsigned HDR_LEFT_BIT  = 0;
    localparam int unsigned HDR_XSIGN_BIT = 4;
    localparam int unsigned HDR_YSIGN_BIT = 5;

    // Packet size register
    localparam int unsigned SIZE_W     = 3;
    localparam logic [SIZE_W-1:0] SIZE_PLAIN = 3'd3;
    localparam logic [SIZE_W-1:0] SIZE_WHEEL = 3'd4;

    // Command queue between front and back
    localparam int unsigned CMDQ_DEPTH = 2;
    localparam int unsigned CMDQ_PTR_W = 1;
    localparam int unsigned CMDQ_CNT_W = CMDQ_PTR_W + 1;

    // One complete packet, as handed from front to back
    typedef struct packed {
        logic       left;
        logic       x_sign;
        logic       y_sign;
        logic [7:0] x_byte;
        logic [7:0] y_byte;
        logic       wheel_en;
        logic [3:0] wheel;
    } t_pkt_cmd;

    // One result event
    typedef struct packed {
        t_evt_kind         event_kind;
        logic [11:0]       cursor_x;
        logic [11:0]       cursor_y;
        logic signed [3:0] wheel_delta;
        logic              last_event;
    } t_evt;

endpackage

### hdl/ps2m_if.sv
interface ps2m_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ps2m_event_if import ps2m_pkg::*;;
    logic              valid;
    logic              ready;
    t_evt_kind         event_kind;
    logic [11:0]       cursor_x;
    logic [11:0]       cursor_y;
    logic signed [3:0] wheel_delta;
    logic              last_event;

    modport source (
        output valid, output event_kind, output cursor_x, output cursor_y,
        output wheel_delta, output last_event, input ready
    );
    modport sink (
        input valid, input event_kind, input cursor_x, input cursor_y,
        input wheel_delta, input last_event, output ready
    );
endinterface

### hdl/ps2m_cmd_fifo.sv
module ps2m_cmd_fifo import ps2m_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_pkt_cmd i_cmd,
    output logic     o_full,
    input  logic     i_pop,
    output t_pkt_cmd o_cmd,
    output logic     o_empty
);

    t_pkt_cmd              r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_count;

    assign o_full  = (r_count == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hdl/ps2m_front.sv
module ps2m_front import ps2m_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_full,
    output logic              o_push,
    output t_pkt_cmd          o_cmd
);

    logic [SIZE_W-1:0] r_size;
    logic [1:0]        r_idx;
    logic [1:0]        n_idx;
    logic [7:0]        r_bytes [3];

    logic              accept;
    logic              wide_pkt;
    logic [SIZE_W-1:0] size_eff;
    logic              hdr_ok;
    logic              collect;

    assign o_ready    = !i_full;
    assign accept     = i_valid && o_ready;
    assign wide_pkt   = (r_size == SIZE_WHEEL);
    assign size_eff   = wide_pkt ? SIZE_WHEEL : SIZE_PLAIN;
    assign hdr_ok     = ((i_rx_byte & HDR_SYNC_MASK) != 8'h00)
                     && ((i_rx_byte & HDR_OVF_MASK) == 8'h00);
    assign collect    = ({1'b0, r_idx} + 3'd1) < size_eff;

    always_comb begin
        n_idx  = r_idx;
        o_push = 1'b0;
        if (accept) begin
            if (r_idx == 2'd0 && !hdr_ok) begin
                n_idx = r_idx;              // drop stray byte
            end else if (collect) begin
                n_idx = r_idx + 2'd1;
            end else begin
                n_idx  = 2'd0;
                o_push = 1'b1;
            end
        end
    end

    always_comb begin
        o_cmd.left     = r_bytes[0][HDR_LEFT_BIT];
        o_cmd.x_sign   = r_bytes[0][HDR_XSIGN_BIT];
        o_cmd.y_sign   = r_bytes[0][HDR_YSIGN_BIT];
        o_cmd.x_byte   = r_bytes[1];
        o_cmd.y_byte   = (r_idx == 2'd2) ? i_rx_byte : r_bytes[2];
        o_cmd.wheel_en = wide_pkt;
        o_cmd.wheel    = i_rx_byte[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (accept && collect && !(r_idx == 2'd0 && !hdr_ok)) begin
            r_bytes[r_idx] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_PLAIN;
            r_idx  <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            r_idx <= n_idx;
        end
    end

endmodule

### hdl/ps2m_back.sv
module ps2m_back import ps2m_pkg::*; #(
    parameter int unsigned CURSOR_MAX = 4095
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_empty,
    input  t_pkt_cmd i_cmd,
    output logic     o_pop,
    output logic     o_valid,
    input  logic     i_ready,
    output t_evt     o_evt
);

    localparam int unsigned POS_W = ($clog2(CURSOR_MAX + 1) > 12) ?
                                    $clog2(CURSOR_MAX + 1) : 12;
    localparam int unsigned SUM_W = POS_W + 2;
    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(CURSOR_MAX);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(CURSOR_MAX);
    localparam logic [POS_W-1:0] RST_X   = POS_W'(320);
    localparam logic [POS_W-1:0] RST_Y   = POS_W'(240);

    logic             r_valid,      n_valid;
    t_evt             r_evt,        n_evt;
    logic [POS_W-1:0] r_x,          n_x;
    logic [POS_W-1:0] r_y,          n_y;
    logic             r_left,       n_left;
    logic             r_pend_wheel, n_pend_wheel;
    logic             r_pend_btn,   n_pend_btn;
    logic [3:0]       r_wheel,      n_wheel;

    logic                    out_free;
    logic signed [8:0]       dx;
    logic signed [8:0]       dy_raw;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [POS_W-1:0]        new_x;
    logic [POS_W-1:0]        new_y;
    logic                    wheel_hit;
    logic                    btn_hit;

    assign o_valid  = r_valid;
    assign o_evt    = r_evt;
    assign out_free = !r_valid || i_ready;

    // Cursor update for the packet at the head of the queue
    always_comb begin
        dx     = $signed({i_cmd.x_sign, i_cmd.x_byte});
        dy_raw = $signed({i_cmd.y_sign, i_cmd.y_byte});
        sum_x  = $signed({2'b00, r_x}) + SUM_W'(dx);
        sum_y  = $signed({2'b00, r_y}) - SUM_W'(dy_raw);
        if (sum_x[SUM_W-1]) begin
            new_x = '0;
        end else if (sum_x > SUM_MAX) begin
            new_x = POS_MAX;
        end else begin
            new_x = sum_x[POS_W-1:0];
        end
        if (sum_y[SUM_W-1]) begin
            new_y = '0;
        end else if (sum_y > SUM_MAX) begin
            new_y = POS_MAX;
        end else begin
            new_y = sum_y[POS_W-1:0];
        end
        wheel_hit = i_cmd.wheel_en && (i_cmd.wheel != 4'h0);
        btn_hit   = (i_cmd.left != r_left);
    end

    // Event sequencer: move, then wheel, then button, one per cycle while the output is free
    always_comb begin
        n_valid      = r_valid;
        n_evt        = r_evt;
        n_x          = r_x;
        n_y          = r_y;
        n_left       = r_left;
        n_pend_wheel = r_pend_wheel;
        n_pend_btn   = r_pend_btn;
        n_wheel      = r_wheel;
        o_pop        = 1'b0;
        if (out_free) begin
            if (r_pend_wheel) begin
                n_valid            = 1'b1;
                n_evt.event_kind   = EVT_WHEEL;
                n_evt.cursor_x     = r_x[11:0];
                n_evt.cursor_y     = r_y[11:0];
                n_evt.wheel_delta  = $signed(r_wheel);
                n_evt.last_event   = !r_pend_btn;
                n_pend_wheel       = 1'b0;
            end else if (r_pend_btn) begin
                n_valid            = 1'b1;
                n_evt.event_kind   = r_left ? EVT_DOWN : EVT_UP;
                n_evt.cursor_x     = r_x[11:0];
                n_evt.cursor_y     = r_y[11:0];
                n_evt.wheel_delta  = 4'sd0;
                n_evt.last_event   = 1'b1;
                n_pend_btn         = 1'b0;
            end else if (!i_empty) begin
                o_pop              = 1'b1;
                n_valid            = 1'b1;
                n_x                = new_x;
                n_y                = new_y;
                n_left             = i_cmd.left;
                n_wheel            = i_cmd.wheel;
                n_pend_wheel       = wheel_hit;
                n_pend_btn         = btn_hit;
                n_evt.event_kind   = EVT_MOVE;
                n_evt.cursor_x     = new_x[11:0];
                n_evt.cursor_y     = new_y[11:0];
                n_evt.wheel_delta  = 4'sd0;
                n_evt.last_event   = !(wheel_hit || btn_hit);
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_evt   <= n_evt;
        r_wheel <= n_wheel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_x          <= RST_X;
            r_y          <= RST_Y;
            r_left       <= 1'b0;
            r_pend_wheel <= 1'b0;
            r_pend_btn   <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_x          <= n_x;
            r_y          <= n_y;
            r_left       <= n_left;
            r_pend_wheel <= n_pend_wheel;
            r_pend_btn   <= n_pend_btn;
        end
    end

endmodule

### hdl/ps2_mouse_packet_tracker.sv
// Channel   Direction  Signals                                        Request
// i_rx      in         valid, ready, rx_byte[7:0]                      one mouse byte
// o_evt     out        valid, ready, event_kind, cursor_x, cursor_y,   one event
//                      wheel_delta, last_event
// i_cfg_*   in         i_cfg_we, i_cfg_wdata[2:0]                      packet size write
//
// Cycles: a byte is taken every cycle while the two-entry packet queue has room.
// A completing byte yields 1 to 3 events, issued one per cycle while o_evt.ready
// is high from the single output register; the move event is registered there
// as the back end pops the packet from the queue head.
// Reset: synchronous, active low; cursor returns to (320, 240), button released,
// packet size 3, queue empty.
// Stalls: the queue decouples input and output; o_evt.ready low holds the
// event and stops the back end, and i_rx.ready falls only when the queue fills.
module ps2_mouse_packet_tracker import ps2m_pkg::*; #(
    parameter int unsigned CURSOR_MAX = 4095
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    ps2m_byte_if.sink         i_rx,
    ps2m_event_if.source      o_evt
);

    // Front to queue
    logic     push;
    logic     full;
    t_pkt_cmd push_cmd;

    // Queue to back
    logic     pop;
    logic     empty;
    t_pkt_cmd head_cmd;

    // Back output register
    t_evt     evt;
    logic     evt_valid;

    // Front: accept bytes, drop stray headers, assemble packets
    ps2m_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_rx.valid),
        .o_ready     (i_rx.ready),
        .i_rx_byte   (i_rx.rx_byte),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // Hold complete packets until the back end is free
    ps2m_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty)
    );

    // Back: update cursor and button state, issue events
    ps2m_back #(
        .CURSOR_MAX (CURSOR_MAX)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_valid (evt_valid),
        .i_ready (o_evt.ready),
        .o_evt   (evt)
    );

    assign o_evt.valid       = evt_valid;
    assign o_evt.event_kind  = evt.event_kind;
    assign o_evt.cursor_x    = evt.cursor_x;
    assign o_evt.cursor_y    = evt.cursor_y;
    assign o_evt.wheel_delta = evt.wheel_delta;
    assign o_evt.last_event  = evt.last_event;

endmodule

### hdl/ps2m_checker.sv
module ps2m_checker import ps2m_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_evt_valid,
    input logic              i_evt_ready,
    input t_evt_kind         i_event_kind,
    input logic [11:0]       i_cursor_x,
    input logic [11:0]       i_cursor_y,
    input logic signed [3:0] i_wheel_delta,
    input logic              i_last_event
);

    // No event right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_evt_valid)
        else $error("event valid after reset");

    // Stalled event holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt_valid && !i_evt_ready |=> i_evt_valid
            && $stable(i_event_kind) && $stable(i_cursor_x)
            && $stable(i_cursor_y) && $stable(i_wheel_delta)
            && $stable(i_last_event))
        else $error("stalled event changed");

    // Wheel delta is nonzero exactly on wheel events
    a_wheel_delta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt_valid |-> ((i_event_kind == EVT_WHEEL) == (i_wheel_delta != 4'sd0)))
        else $error("wheel delta does not match event kind");

    // Events of one byte follow back to back with the same cursor
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt_valid && i_evt_ready && !i_last_event |=> i_evt_valid
            && $stable(i_cursor_x) && $stable(i_cursor_y)
            && (i_event_kind != EVT_MOVE))
        else $error("broken event burst");

endmodule

bind ps2_mouse_packet_tracker ps2m_checker u_ps2m_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_evt_valid   (o_evt.valid),
    .i_evt_ready   (o_evt.ready),
    .i_event_kind  (o_evt.event_kind),
    .i_cursor_x    (o_evt.cursor_x),
    .i_cursor_y    (o_evt.cursor_y),
    .i_wheel_delta (o_evt.wheel_delta),
    .i_last_event  (o_evt.last_event)
);

### test/ps2_mouse_packet_tracker_tb.sv
`timescale 1ns / 1ps

module ps2_mouse_packet_tracker_tb;
    import ps2m_pkg::*;

    localparam int unsigned CURSOR_LIMIT = 4095;
    localparam int          SETTLE_CYCLES = 16;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [SIZE_W-1:0] i_cfg_wdata;

    ps2m_byte_if  rx_if ();
    ps2m_event_if evt_if ();

    ps2_mouse_packet_tracker #(
        .CURSOR_MAX(CURSOR_LIMIT)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_rx       (rx_if),
        .o_evt      (evt_if)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mouse bytes waiting to be sent, and events the tracker is expected to emit.
    logic [7:0] byte_backlog[$];
    t_evt       due_events[$];

    int  bytes_queued = 0;
    int  bytes_taken  = 0;
    int  mismatches   = 0;
    bit  gaps_on      = 1'b1;
    int  rx_gap       = 0;
    int  evt_stall    = 0;

    // Shadow of the tracker state, advanced once per accepted byte.
    logic [SIZE_W-1:0] trk_size = SIZE_PLAIN;
    int                trk_idx  = 0;
    logic [7:0]        trk_bytes[3];
    int                cur_x    = 320;
    int                cur_y    = 240;
    logic              btn_held = 1'b0;

    // Direction of the current streak of large moves, so the cursor reaches its edges.
    logic dir_x = 1'b0;
    logic dir_y = 1'b0;
    int   streak_len = 0;

    function automatic int clamp_cursor(input int v);
        if (v < 0) return 0;
        if (v > int'(CURSOR_LIMIT)) return int'(CURSOR_LIMIT);
        return v;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    // Advance the shadow state by one byte and queue the events it causes.
    task automatic track_byte(input logic [7:0] b);
        int         pkt_len;
        int         slot;
        int         dx;
        int         dy;
        logic [7:0] hdr;
        logic [7:0] yb;
        logic       left;
        t_evt       ev;
        pkt_len = (trk_size == SIZE_WHEEL) ? 4 : 3;
        slot    = trk_idx;
        // Drop anything that is not a sync'd header at the start of a packet.
        if (slot == 0 && !((b & HDR_SYNC_MASK) != 0 && (b & HDR_OVF_MASK) == 0)) return;
        if (slot + 1 < pkt_len) begin
            if (slot < 3) trk_bytes[slot[1:0]] = b;
            trk_idx = slot + 1;
            return;
        end
        // Packet complete. With three bytes held and the size lowered to 3,
        // the y byte comes from the store and this byte is only a trigger.
        trk_idx = 0;
        hdr  = trk_bytes[0];
        yb   = (slot == 2) ? b : trk_bytes[2];
        dx   = int'(trk_bytes[1]) - (hdr[HDR_XSIGN_BIT] ? 256 : 0);
        dy   = (hdr[HDR_YSIGN_BIT] ? 256 : 0) - int'(yb);
        left = hdr[HDR_LEFT_BIT];
        cur_x = clamp_cursor(cur_x + dx);
        cur_y = clamp_cursor(cur_y + dy);
        ev = '0;
        ev.event_kind = EVT_MOVE;
        ev.cursor_x   = cur_x[11:0];
        ev.cursor_y   = cur_y[11:0];
        due_events.push_back(ev);
        if (pkt_len == 4 && b[3:0] != 4'd0) begin
            ev.event_kind  = EVT_WHEEL;
            ev.wheel_delta = b[3:0];
            due_events.push_back(ev);
        end
        if (left != btn_held) begin
            btn_held       = left;
            ev.event_kind  = left ? EVT_DOWN : EVT_UP;
            ev.wheel_delta = 4'sd0;
            due_events.push_back(ev);
        end
        due_events[$].last_event = 1'b1;
    endtask

    task automatic check_event();
        t_evt want;
        if (due_events.size() == 0) begin
            flag_mismatch($sformatf("unexpected event kind %0d", evt_if.event_kind));
            return;
        end
        want = due_events.pop_front();
        if (evt_if.event_kind !== want.event_kind)
            flag_mismatch($sformatf("event_kind got %0d want %0d",
                                    evt_if.event_kind, want.event_kind));
        if (evt_if.cursor_x !== want.cursor_x)
            flag_mismatch($sformatf("cursor_x got %0d want %0d",
                                    evt_if.cursor_x, want.cursor_x));
        if (evt_if.cursor_y !== want.cursor_y)
            flag_mismatch($sformatf("cursor_y got %0d want %0d",
                                    evt_if.cursor_y, want.cursor_y));
        if (evt_if.wheel_delta !== want.wheel_delta)
            flag_mismatch($sformatf("wheel_delta got %0d want %0d",
                                    evt_if.wheel_delta, want.wheel_delta));
        if (evt_if.last_event !== want.last_event)
            flag_mismatch($sformatf("last_event got %0d want %0d",
                                    evt_if.last_event, want.last_event));
    endtask

    // Byte driver: hold a request until it is taken, insert random gaps between requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
        end else begin
            if (rx_if.valid && rx_if.ready) begin
                track_byte(rx_if.rx_byte);
                bytes_taken++;
            end
            if (!(rx_if.valid && !rx_if.ready)) begin
                if (rx_gap > 0) begin
                    rx_gap--;
                    rx_if.valid <= 1'b0;
                end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                    rx_gap = $urandom_range(1, 16) - 1;
                    rx_if.valid <= 1'b0;
                end else if (byte_backlog.size() != 0) begin
                    rx_if.valid   <= 1'b1;
                    rx_if.rx_byte <= byte_backlog.pop_front();
                end else begin
                    rx_if.valid <= 1'b0;
                end
            end
        end
    end

    // Event monitor: check every taken event, stall ready in random bursts.
    always @(posedge i_clk) begin
        if (i_rst_n && evt_if.valid && evt_if.ready) check_event();
        if (evt_stall > 0) begin
            evt_stall--;
            evt_if.ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            evt_stall = $urandom_range(1, 16) - 1;
            evt_if.ready <= 1'b0;
        end else begin
            evt_if.ready <= 1'b1;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        byte_backlog.push_back(b);
        bytes_queued++;
    endtask

    // Queue one packet at the size currently programmed.
    task automatic queue_packet(input logic [7:0] hdr, input logic [7:0] xb,
                                input logic [7:0] yb, input logic [7:0] wb);
        push_byte(hdr);
        push_byte(xb);
        push_byte(yb);
        if (trk_size == SIZE_WHEEL) push_byte(wb);
    endtask

    // Wait until every byte is taken and every event has come, then let the block settle.
    task automatic wait_drain();
        do @(negedge i_clk);
        while (bytes_taken != bytes_queued || due_events.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Finish a partial packet with filler so the next phase starts on a header.
    task automatic realign();
        int pkt_len;
        pkt_len = (trk_size == SIZE_WHEEL) ? 4 : 3;
        if (trk_idx != 0) begin
            repeat (pkt_len - trk_idx) push_byte(8'h00);
            wait_drain();
        end
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        trk_size     = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly well-formed packets with random content, some stray bytes and cut-off packets.
    task automatic feed_random(input int n_bytes);
        int         start;
        int         pick;
        logic [7:0] hdr;
        logic [7:0] xb;
        logic [7:0] yb;
        start = bytes_queued;
        while (bytes_queued - start < n_bytes) begin
            pick = $urandom_range(0, 9);
            hdr  = 8'($urandom_range(0, 255));
            hdr[7:6] = 2'b00;
            hdr[3]   = 1'b1;
            if (pick == 0) begin
                push_byte(8'($urandom_range(0, 255)));
            end else if (pick == 1) begin
                push_byte(hdr);
                push_byte(8'($urandom_range(0, 255)));
            end else begin
                streak_len++;
                if (streak_len == 12) begin
                    streak_len = 0;
                    dir_x = ~dir_x;
                    dir_y = 1'($urandom_range(0, 1));
                end
                xb = 8'($urandom_range(0, 255));
                yb = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 9) < 6) begin
                    hdr[HDR_XSIGN_BIT] = dir_x;
                    hdr[HDR_YSIGN_BIT] = dir_y;
                    xb = dir_x ? 8'h00 : 8'hFF;
                    yb = dir_y ? 8'h00 : 8'hFF;
                end
                queue_packet(hdr, xb, yb, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        evt_if.ready  = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Drop bytes that fail the header check: no sync bit, overflow bits set.
        push_byte(8'h00);
        push_byte(8'hC8);
        push_byte(8'h48);
        push_byte(8'hF7);
        // Button down with dx +127; then dx -256 with y hitting the low edge.
        queue_packet(8'h09, 8'h7F, 8'h00, 8'h00);
        queue_packet(8'h18, 8'h00, 8'hFF, 8'h00);
        queue_packet(8'h38, 8'h00, 8'h00, 8'h00);
        queue_packet(8'h08, 8'hFF, 8'h80, 8'h00);
        wait_drain();

        // Size 7 behaves as 3.
        write_size(3'd7);
        feed_random(18);
        wait_drain();
        realign();

        // Wheel mode: zero wheel, +7, -8, and upper nibble ignored.
        write_size(SIZE_WHEEL);
        queue_packet(8'h08, 8'h01, 8'h01, 8'h00);
        queue_packet(8'h09, 8'h00, 8'h00, 8'h07);
        queue_packet(8'h08, 8'h00, 8'h00, 8'hF8);
        queue_packet(8'h08, 8'h02, 8'h02, 8'hFF);
        feed_random(22);
        wait_drain();
        realign();

        // Lower the size with three bytes held: the next byte only closes the packet.
        push_byte(8'h09);
        push_byte(8'h10);
        push_byte(8'h20);
        wait_drain();
        write_size(SIZE_PLAIN);
        push_byte(8'h55);
        wait_drain();

        // Size 0 behaves as 3; raise it to 4 with two bytes held.
        write_size(3'd0);
        push_byte(8'h08);
        push_byte(8'h05);
        wait_drain();
        write_size(SIZE_WHEEL);
        push_byte(8'h06);
        push_byte(8'h01);
        wait_drain();
        realign();

        // Last stretch at full rate, no gaps on either side.
        write_size(SIZE_PLAIN);
        gaps_on = 1'b0;
        feed_random(22);
        wait_drain();

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### ps2_mouse_packet_tracker.f
hdl/ps2m_pkg.sv
hdl/ps2m_if.sv
hdl/ps2m_cmd_fifo.sv
hdl/ps2m_front.sv
hdl/ps2m_back.sv
hdl/ps2_mouse_packet_tracker.sv
hdl/ps2m_checker.sv
test/ps2_mouse_packet_tracker_tb.sv
